/* src/jjs_pkg.sv */
`default_nettype none

package jjs_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int PERIOD_W   = 8;
  localparam int RATE_W     = 16;
  localparam int CM_W       = 24;
  localparam int LEVEL_W    = 3;
  localparam int NUM_SPEEDS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [PERIOD_W-1:0]   period_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_SPEED  = 2'd2,
    FUNC_ORIGIN = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_TH   = 3'd0,
    REG_HIGH_TH  = 3'd1,
    REG_PERIOD_1 = 3'd2,
    REG_PERIOD_2 = 3'd3,
    REG_PERIOD_3 = 3'd4,
    REG_PERIOD_4 = 3'd5
  } reg_idx_t;

  localparam sample_t RST_LOW_TH  = 10'd500;
  localparam sample_t RST_HIGH_TH = 10'd600;
  localparam period_t RST_PERIOD_1 = 8'd2;
  localparam period_t RST_PERIOD_2 = 8'd5;
  localparam period_t RST_PERIOD_3 = 8'd10;
  localparam period_t RST_PERIOD_4 = 8'd30;
  localparam logic [RATE_W-1:0] RATE_STEP = 16'd2;

  // command from the decoder to one axis
  typedef struct packed {
    logic step;
    logic up;
    logic dir_level;
    logic clear;
    logic refresh;
  } axis_cmd_t;

  // post-update view of one axis
  typedef struct packed {
    logic                   step_pin;
    logic                   dir_pin;
    logic signed [CM_W-1:0] cm;
  } axis_view_t;

  typedef struct packed {
    logic                   step_x;
    logic                   dir_x;
    logic                   step_y;
    logic                   dir_y;
    logic                   step_z;
    logic                   dir_z;
    logic                   moving;
    logic                   report_now;
    logic signed [CM_W-1:0] x_cm;
    logic signed [CM_W-1:0] y_cm;
    logic signed [CM_W-1:0] z_cm;
    logic [LEVEL_W-1:0]     speed_level;
  } result_t;

endpackage

`default_nettype wire

/* src/jjs_axis.sv */
`default_nettype none

module jjs_axis #(
  parameter int POSITION_WIDTH = 32,
  parameter int STEPS_PER_CM   = 400,
  parameter bit STEP_RST       = 1'b0,
  parameter bit DIR_RST        = 1'b1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jjs_pkg::axis_cmd_t cmd,
  output jjs_pkg::axis_view_t     view
);
  import jjs_pkg::*;

  localparam int REM_W = (STEPS_PER_CM > 1) ? $clog2(STEPS_PER_CM) : 1;
  localparam int EXT_W = (POSITION_WIDTH > CM_W) ? POSITION_WIDTH : CM_W;
  localparam logic [REM_W-1:0] REM_TOP = REM_W'(STEPS_PER_CM - 1);

  logic [POSITION_WIDTH-1:0] count_r, count_nxt;
  logic [POSITION_WIDTH-1:0] quot_r, quot_nxt;   // |count| / STEPS_PER_CM, always tracked
  logic [REM_W-1:0]          rem_r, rem_nxt;     // |count| % STEPS_PER_CM
  logic [POSITION_WIDTH-1:0] cm_r, cm_nxt;       // magnitude latched at the last refresh
  logic                      step_pin_r, step_pin_nxt;
  logic                      dir_pin_r, dir_pin_nxt;

  logic                      neg, is_zero, most_neg, grow;
  logic [EXT_W-1:0]          cm_ext;
  logic [CM_W-1:0]           mag_lo;

  always_comb begin
    neg      = count_r[POSITION_WIDTH-1];
    is_zero  = (count_r == '0);
    most_neg = neg && (count_r[POSITION_WIDTH-2:0] == '0);
    // does |count| go up by one with this step?
    grow     = cmd.up ? !neg : (is_zero || (neg && !most_neg));

    count_nxt    = count_r;
    quot_nxt     = quot_r;
    rem_nxt      = rem_r;
    cm_nxt       = cm_r;
    step_pin_nxt = step_pin_r;
    dir_pin_nxt  = dir_pin_r;

    if (cmd.clear) begin
      count_nxt = '0;
      quot_nxt  = '0;
      rem_nxt   = '0;
    end else if (cmd.step) begin
      count_nxt    = cmd.up ? count_r + 1'b1 : count_r - 1'b1;
      step_pin_nxt = !step_pin_r;
      dir_pin_nxt  = cmd.dir_level;
      if (grow) begin
        if (rem_r == REM_TOP) begin
          rem_nxt  = '0;
          quot_nxt = quot_r + 1'b1;
        end else begin
          rem_nxt  = rem_r + 1'b1;
        end
      end else begin
        if (rem_r == '0) begin
          rem_nxt  = REM_TOP;
          quot_nxt = quot_r - 1'b1;
        end else begin
          rem_nxt  = rem_r - 1'b1;
        end
      end
    end

    // any motion step relatches the magnitude of every axis, moved or not
    if (cmd.refresh) cm_nxt = quot_nxt;

    cm_ext = EXT_W'(cm_nxt);
    mag_lo = cm_ext[CM_W-1:0];

    view.step_pin = step_pin_nxt;
    view.dir_pin  = dir_pin_nxt;
    view.cm       = count_nxt[POSITION_WIDTH-1] ? -$signed(mag_lo) : $signed(mag_lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      quot_r     <= '0;
      rem_r      <= '0;
      cm_r       <= '0;
      step_pin_r <= STEP_RST;
      dir_pin_r  <= DIR_RST;
    end else begin
      count_r    <= count_nxt;
      quot_r     <= quot_nxt;
      rem_r      <= rem_nxt;
      cm_r       <= cm_nxt;
      step_pin_r <= step_pin_nxt;
      dir_pin_r  <= dir_pin_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= REM_TOP)
    else $error("remainder out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0) && (quot_r == '0) && (rem_r == '0))
    else $error("origin did not clear the count");

  a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !cmd.clear |=> step_pin_r != $past(step_pin_r))
    else $error("step pin did not toggle");

  a_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (quot_r == '0) && (rem_r == '0))
    else $error("zero count with nonzero quotient");
`endif

endmodule

`default_nettype wire

/* src/joystick_jog_stepper_controller_unit.sv */
// Three-axis joystick jog controller for stepper motors.
// Input channel (in_valid / in_stall) carries one word per event: a timer
// tick, a joystick sample with the Z button and switch levels, a speed
// button press, or a set-origin command. Every accepted word yields exactly
// one result word on the output channel (out_valid / out_stall) with the six
// pin levels, moving and report flags, signed centimetre positions per axis
// and the current speed level.
// Accepted words are registered, one word per cycle while out_stall is low.
// Each step touches the position count and its running quotient and
// remainder by one, so no divider sits in the path.
// The output register is backed by a one-word skid register; in_stall rises
// only when both hold words, i.e. after the receiver has stalled with a word
// already waiting and another was accepted. Stalled output words stay put.
// Thresholds and the four periods are written over the cfg_ port (always
// ready); unknown indexes are dropped. Write only while the block is idle.
// Reset (rst_n low, synchronous) restores register defaults, clears counts,
// the rate counter and speed state, and sets the pins to their idle levels.
`default_nettype none

module joystick_jog_stepper_controller_unit #(
  parameter int STEPS_PER_CM   = 400,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire jjs_pkg::func_t       in_func,
  input  wire jjs_pkg::sample_t     in_joy_x,
  input  wire jjs_pkg::sample_t     in_joy_y,
  input  wire logic                 in_z_button_pressed,
  input  wire logic                 in_z_up_selected,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_step_x,
  output logic                      out_dir_x,
  output logic                      out_step_y,
  output logic                      out_dir_y,
  output logic                      out_step_z,
  output logic                      out_dir_z,
  output logic                      out_moving,
  output logic                      out_report_now,
  output logic signed [23:0]        out_x_cm,
  output logic signed [23:0]        out_y_cm,
  output logic signed [23:0]        out_z_cm,
  output logic [2:0]                out_speed_level,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire jjs_pkg::cfg_idx_t    cfg_index,
  input  wire jjs_pkg::cfg_data_t   cfg_data
);
  import jjs_pkg::*;

  // configuration
  sample_t low_th_r, high_th_r;
  period_t period_r [NUM_SPEEDS];

  // control state
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [2:0]        press_r, press_nxt;
  logic [1:0]        speed_idx_r, speed_idx_nxt;
  logic              pending_r, pending_nxt;

  // output register plus skid
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;

  logic       accept, pop, fire;
  logic       xp, xn, xm, yp, yn, ym;
  logic       mv_x, up_x, mv_y, up_y;
  logic       moving, report;
  logic [RATE_W:0] rate_sum;
  period_t    period_sel;
  logic [LEVEL_W-1:0] lvl_tab [NUM_SPEEDS];
  axis_cmd_t  cmd_x, cmd_y, cmd_z;
  axis_view_t view_x, view_y, view_z;
  result_t    res_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_th_r    <= RST_LOW_TH;
      high_th_r   <= RST_HIGH_TH;
      period_r[0] <= RST_PERIOD_1;
      period_r[1] <= RST_PERIOD_2;
      period_r[2] <= RST_PERIOD_3;
      period_r[3] <= RST_PERIOD_4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_TH:   low_th_r    <= cfg_data;
        REG_HIGH_TH:  high_th_r   <= cfg_data;
        REG_PERIOD_1: period_r[0] <= cfg_data[PERIOD_W-1:0];
        REG_PERIOD_2: period_r[1] <= cfg_data[PERIOD_W-1:0];
        REG_PERIOD_3: period_r[2] <= cfg_data[PERIOD_W-1:0];
        REG_PERIOD_4: period_r[3] <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // speed level of each index: first period register with the same value
  always_comb begin
    for (int k = 0; k < NUM_SPEEDS; k++) begin
      priority if (period_r[0] == period_r[k]) lvl_tab[k] = LEVEL_W'(1);
      else if (period_r[1] == period_r[k])      lvl_tab[k] = LEVEL_W'(2);
      else if (period_r[2] == period_r[k])      lvl_tab[k] = LEVEL_W'(3);
      else                                      lvl_tab[k] = LEVEL_W'(4);
    end
  end

  always_comb begin
    xp = in_joy_x < low_th_r;
    xn = in_joy_x > high_th_r;
    xm = (in_joy_x > low_th_r) && (in_joy_x < high_th_r);
    yp = in_joy_y < low_th_r;
    yn = in_joy_y > high_th_r;
    ym = (in_joy_y > low_th_r) && (in_joy_y < high_th_r);

    mv_x = 1'b0; up_x = 1'b0; mv_y = 1'b0; up_y = 1'b0;
    priority if (xp && yp) begin mv_x = 1'b1; up_x = 1'b1; mv_y = 1'b1; up_y = 1'b1; end
    else if (xp && ym)     begin mv_x = 1'b1; up_x = 1'b1; end
    else if (xn && ym)     begin mv_x = 1'b1; end
    else if (xp && yn)     begin mv_x = 1'b1; up_x = 1'b1; mv_y = 1'b1; end
    else if (yn && xm)     begin mv_y = 1'b1; end
    else if (yp && xm)     begin mv_y = 1'b1; up_y = 1'b1; end
    else if (xn && yn)     begin mv_x = 1'b1; mv_y = 1'b1; end
    else if (xn && yp)     begin mv_x = 1'b1; mv_y = 1'b1; up_y = 1'b1; end
    else ;

    period_sel = period_r[speed_idx_r];
    fire = accept && (in_func == FUNC_SAMPLE) && (rate_r >= RATE_W'(period_sel));

    rate_sum      = {1'b0, rate_r} + {1'b0, RATE_STEP};
    rate_nxt      = rate_r;
    press_nxt     = press_r;
    speed_idx_nxt = speed_idx_r;
    pending_nxt   = pending_r;
    moving        = 1'b0;
    report        = 1'b0;

    if (accept) begin
      unique case (in_func)
        FUNC_TICK: begin
          // saturate at all ones
          rate_nxt = rate_sum[RATE_W] ? '1 : rate_sum[RATE_W-1:0];
        end
        FUNC_SAMPLE: begin
          if (fire) rate_nxt = RATE_W'(1);
          if (xn || xp || yn || yp || in_z_button_pressed) begin
            moving      = 1'b1;
            pending_nxt = 1'b1;
          end else if (pending_r) begin
            report      = 1'b1;
            pending_nxt = 1'b0;
          end
        end
        FUNC_SPEED: begin
          press_nxt = press_r + 1'b1;
          if (press_nxt >= 3'd1 && press_nxt <= 3'd4) speed_idx_nxt = 2'(press_nxt - 1'b1);
          else press_nxt = '0;
          pending_nxt = 1'b1;
        end
        FUNC_ORIGIN: ;
        default: ;
      endcase
    end

    cmd_x.step      = fire && mv_x;
    cmd_x.up        = up_x;
    cmd_x.dir_level = !up_x;
    cmd_x.clear     = accept && (in_func == FUNC_ORIGIN);
    cmd_x.refresh   = fire;
    cmd_y.step      = fire && mv_y;
    cmd_y.up        = up_y;
    cmd_y.dir_level = !up_y;
    cmd_y.clear     = cmd_x.clear;
    cmd_y.refresh   = fire;
    cmd_z.step      = fire && in_z_button_pressed;
    cmd_z.up        = in_z_up_selected;
    cmd_z.dir_level = in_z_up_selected;
    cmd_z.clear     = cmd_x.clear;
    cmd_z.refresh   = fire;
  end

  jjs_axis #(
    .POSITION_WIDTH(POSITION_WIDTH), .STEPS_PER_CM(STEPS_PER_CM),
    .STEP_RST(1'b0), .DIR_RST(1'b1)
  ) u_axis_x (.clk(clk), .rst_n(rst_n), .cmd(cmd_x), .view(view_x));

  jjs_axis #(
    .POSITION_WIDTH(POSITION_WIDTH), .STEPS_PER_CM(STEPS_PER_CM),
    .STEP_RST(1'b1), .DIR_RST(1'b0)
  ) u_axis_y (.clk(clk), .rst_n(rst_n), .cmd(cmd_y), .view(view_y));

  jjs_axis #(
    .POSITION_WIDTH(POSITION_WIDTH), .STEPS_PER_CM(STEPS_PER_CM),
    .STEP_RST(1'b1), .DIR_RST(1'b1)
  ) u_axis_z (.clk(clk), .rst_n(rst_n), .cmd(cmd_z), .view(view_z));

  always_comb begin
    res_new.step_x      = view_x.step_pin;
    res_new.dir_x       = view_x.dir_pin;
    res_new.step_y      = view_y.step_pin;
    res_new.dir_y       = view_y.dir_pin;
    res_new.step_z      = view_z.step_pin;
    res_new.dir_z       = view_z.dir_pin;
    res_new.moving      = moving;
    res_new.report_now  = report;
    res_new.x_cm        = view_x.cm;
    res_new.y_cm        = view_y.cm;
    res_new.z_cm        = view_z.cm;
    res_new.speed_level = lvl_tab[speed_idx_nxt];
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_data_nxt  = res_new;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r       <= '0;
      press_r      <= '0;
      speed_idx_r  <= '0;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      rate_r       <= rate_nxt;
      press_r      <= press_nxt;
      speed_idx_r  <= speed_idx_nxt;
      pending_r    <= pending_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_step_x      = out_data_r.step_x;
  assign out_dir_x       = out_data_r.dir_x;
  assign out_step_y      = out_data_r.step_y;
  assign out_dir_y       = out_data_r.dir_y;
  assign out_step_z      = out_data_r.step_z;
  assign out_dir_z       = out_data_r.dir_z;
  assign out_moving      = out_data_r.moving;
  assign out_report_now  = out_data_r.report_now;
  assign out_x_cm        = out_data_r.x_cm;
  assign out_y_cm        = out_data_r.y_cm;
  assign out_z_cm        = out_data_r.z_cm;
  assign out_speed_level = out_data_r.speed_level;

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without an output word");

  a_step_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> rate_r == RATE_W'(1))
    else $error("rate counter not rearmed after a step");

  a_report_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.report_now |-> !out_data_r.moving)
    else $error("report raised while moving");

  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    press_r <= 3'd4)
    else $error("speed press state out of range");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import jjs_pkg::*;

  localparam int CM_STEPS = 400;
  localparam cfg_idx_t IDX_SPARE_A = 3'd6;
  localparam cfg_idx_t IDX_SPARE_B = 3'd7;

  typedef struct packed {
    func_t   func;
    sample_t joy_x;
    sample_t joy_y;
    logic    z_btn;
    logic    z_up;
  } jog_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  func_t     in_func = FUNC_TICK;
  sample_t   in_joy_x = '0;
  sample_t   in_joy_y = '0;
  logic      in_z_button_pressed = 1'b0;
  logic      in_z_up_selected = 1'b0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      out_step_x, out_dir_x, out_step_y, out_dir_y, out_step_z, out_dir_z;
  logic      out_moving, out_report_now;
  logic signed [CM_W-1:0] out_x_cm, out_y_cm, out_z_cm;
  logic [LEVEL_W-1:0]     out_speed_level;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data = '0;

  joystick_jog_stepper_controller_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_joy_x            (in_joy_x),
    .in_joy_y            (in_joy_y),
    .in_z_button_pressed (in_z_button_pressed),
    .in_z_up_selected    (in_z_up_selected),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_step_x          (out_step_x),
    .out_dir_x           (out_dir_x),
    .out_step_y          (out_step_y),
    .out_dir_y           (out_dir_y),
    .out_step_z          (out_step_z),
    .out_dir_z           (out_dir_z),
    .out_moving          (out_moving),
    .out_report_now      (out_report_now),
    .out_x_cm            (out_x_cm),
    .out_y_cm            (out_y_cm),
    .out_z_cm            (out_z_cm),
    .out_speed_level     (out_speed_level),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // jog controller mirror: config, counters, pins, positions
  sample_t     lo_th = RST_LOW_TH;
  sample_t     hi_th = RST_HIGH_TH;
  period_t     period [NUM_SPEEDS] = '{RST_PERIOD_1, RST_PERIOD_2, RST_PERIOD_3, RST_PERIOD_4};
  logic [15:0] rate_cnt = '0;
  logic [2:0]  press_cnt = '0;
  logic [1:0]  speed_idx = '0;
  logic        report_due = 1'b0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [31:0] mag_x = '0, mag_y = '0, mag_z = '0;
  logic        pin_sx = 1'b0, pin_dx = 1'b1, pin_sy = 1'b1;
  logic        pin_dy = 1'b0, pin_sz = 1'b1, pin_dz = 1'b1;

  jog_word_t jog_words_q[$];
  result_t   exp_motion_q[$];

  bit took_word = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int n_words = 0;
  int n_results = 0;
  int n_mismatch = 0;

  function automatic logic [31:0] cm_mag(logic [31:0] c);
    logic [31:0] m;
    m = c[31] ? (32'd0 - c) : c;
    return m / CM_STEPS;
  endfunction

  function automatic logic [CM_W-1:0] cm_signed(logic [31:0] c, logic [31:0] m);
    return c[31] ? (24'd0 - m[CM_W-1:0]) : m[CM_W-1:0];
  endfunction

  task automatic predict_motion(jog_word_t w);
    result_t r;
    logic    xp, xn, xm, yp, yn, ym;
    int      mx, my;
    int      lvl;
    r = '0;
    mx = 0;
    my = 0;
    case (w.func)
      FUNC_TICK: rate_cnt = (rate_cnt > 16'hFFFD) ? 16'hFFFF : rate_cnt + RATE_STEP;
      FUNC_SAMPLE: begin
        if (rate_cnt >= {8'd0, period[speed_idx]}) begin
          rate_cnt = 16'd1;
          xp = w.joy_x < lo_th;
          xn = w.joy_x > hi_th;
          xm = w.joy_x > lo_th && w.joy_x < hi_th;
          yp = w.joy_y < lo_th;
          yn = w.joy_y > hi_th;
          ym = w.joy_y > lo_th && w.joy_y < hi_th;
          // priority order matters once the thresholds cross
          if (xp && yp) begin
            mx = 1;
            my = 1;
          end else if (xp && ym) begin
            mx = 1;
          end else if (xn && ym) begin
            mx = -1;
          end else if (xp && yn) begin
            mx = 1;
            my = -1;
          end else if (yn && xm) begin
            my = -1;
          end else if (yp && xm) begin
            my = 1;
          end else if (xn && yn) begin
            mx = -1;
            my = -1;
          end else if (xn && yp) begin
            mx = -1;
            my = 1;
          end
          if (mx != 0) begin
            pin_sx = ~pin_sx;
            pin_dx = (mx < 0);
            pos_x = (mx > 0) ? pos_x + 32'd1 : pos_x - 32'd1;
          end
          if (my != 0) begin
            pin_sy = ~pin_sy;
            pin_dy = (my < 0);
            pos_y = (my > 0) ? pos_y + 32'd1 : pos_y - 32'd1;
          end
          if (w.z_btn) begin
            pin_sz = ~pin_sz;
            pin_dz = w.z_up;
            pos_z = w.z_up ? pos_z + 32'd1 : pos_z - 32'd1;
          end
          mag_x = cm_mag(pos_x);
          mag_y = cm_mag(pos_y);
          mag_z = cm_mag(pos_z);
        end
        if (w.joy_x > hi_th || w.joy_x < lo_th || w.joy_y > hi_th || w.joy_y < lo_th ||
            w.z_btn) begin
          r.moving = 1'b1;
          report_due = 1'b1;
        end else if (report_due) begin
          r.report_now = 1'b1;
          report_due = 1'b0;
        end
      end
      FUNC_SPEED: begin
        press_cnt = press_cnt + 3'd1;
        if (press_cnt >= 3'd1 && press_cnt <= 3'd4) speed_idx = press_cnt[1:0] - 2'd1;
        else press_cnt = 3'd0;
        report_due = 1'b1;
      end
      default: begin
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
      end
    endcase
    // lowest matching level wins
    lvl = 0;
    for (int i = NUM_SPEEDS - 1; i >= 0; i--)
      if (period[i] == period[speed_idx]) lvl = i + 1;
    r.step_x = pin_sx;
    r.dir_x = pin_dx;
    r.step_y = pin_sy;
    r.dir_y = pin_dy;
    r.step_z = pin_sz;
    r.dir_z = pin_dz;
    r.x_cm = cm_signed(pos_x, mag_x);
    r.y_cm = cm_signed(pos_y, mag_y);
    r.z_cm = cm_signed(pos_z, mag_z);
    r.speed_level = lvl[LEVEL_W-1:0];
    exp_motion_q.push_back(r);
  endtask

  function automatic string diff_fields(result_t e, result_t g);
    string s;
    s = "";
    if (e.step_x !== g.step_x) s = {s, " step_x"};
    if (e.dir_x !== g.dir_x) s = {s, " dir_x"};
    if (e.step_y !== g.step_y) s = {s, " step_y"};
    if (e.dir_y !== g.dir_y) s = {s, " dir_y"};
    if (e.step_z !== g.step_z) s = {s, " step_z"};
    if (e.dir_z !== g.dir_z) s = {s, " dir_z"};
    if (e.moving !== g.moving) s = {s, " moving"};
    if (e.report_now !== g.report_now) s = {s, " report_now"};
    if (e.x_cm !== g.x_cm) s = {s, " x_cm"};
    if (e.y_cm !== g.y_cm) s = {s, " y_cm"};
    if (e.z_cm !== g.z_cm) s = {s, " z_cm"};
    if (e.speed_level !== g.speed_level) s = {s, " speed_level"};
    return s;
  endfunction

  function automatic string fmt_word(result_t r);
    return $sformatf("pins sx%b dx%b sy%b dy%b sz%b dz%b mv%b rp%b cm %0d/%0d/%0d lvl %0d",
                     r.step_x, r.dir_x, r.step_y, r.dir_y, r.step_z, r.dir_z, r.moving,
                     r.report_now, r.x_cm, r.y_cm, r.z_cm, r.speed_level);
  endfunction

  // sample outputs, mirror config writes, predict accepted words
  always @(posedge clk) begin
    result_t   got, want;
    jog_word_t w;
    string     diff;
    took_word = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.step_x = out_step_x;
        got.dir_x = out_dir_x;
        got.step_y = out_step_y;
        got.dir_y = out_dir_y;
        got.step_z = out_step_z;
        got.dir_z = out_dir_z;
        got.moving = out_moving;
        got.report_now = out_report_now;
        got.x_cm = out_x_cm;
        got.y_cm = out_y_cm;
        got.z_cm = out_z_cm;
        got.speed_level = out_speed_level;
        n_results++;
        if (exp_motion_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result word %0d: %s", n_results, fmt_word(got));
        end else begin
          want = exp_motion_q.pop_front();
          diff = diff_fields(want, got);
          if (diff != "") begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch on result word %0d:%s", n_results, diff);
              $display("  exp %s", fmt_word(want));
              $display("  got %s", fmt_word(got));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_TH:   lo_th = cfg_data;
          REG_HIGH_TH:  hi_th = cfg_data;
          REG_PERIOD_1: period[0] = cfg_data[PERIOD_W-1:0];
          REG_PERIOD_2: period[1] = cfg_data[PERIOD_W-1:0];
          REG_PERIOD_3: period[2] = cfg_data[PERIOD_W-1:0];
          REG_PERIOD_4: period[3] = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (took_word) begin
        w.func = in_func;
        w.joy_x = in_joy_x;
        w.joy_y = in_joy_y;
        w.z_btn = in_z_button_pressed;
        w.z_up = in_z_up_selected;
        void'(jog_words_q.pop_front());
        n_words++;
        predict_motion(w);
      end
    end
  end

  // sender: valid is held until the word is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took_word)) begin
      if (jog_words_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_func <= jog_words_q[0].func;
        in_joy_x <= jog_words_q[0].joy_x;
        in_joy_y <= jog_words_q[0].joy_y;
        in_z_button_pressed <= jog_words_q[0].z_btn;
        in_z_up_selected <= jog_words_q[0].z_up;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic sample_t pick_axis();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return lo_th;
      3: return hi_th;
      4: return lo_th - 10'd1;
      5: return hi_th + 10'd1;
      6, 7: return sample_t'($urandom_range(lo_th, hi_th));
      default: return sample_t'($urandom_range(1023, 0));
    endcase
  endfunction

  function automatic jog_word_t rand_word(func_t f);
    jog_word_t w;
    w.func = f;
    w.joy_x = pick_axis();
    w.joy_y = pick_axis();
    w.z_btn = ($urandom_range(9) < 4);
    w.z_up = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic push_word(func_t f, sample_t x, sample_t y, logic zb, logic zu);
    jog_words_q.push_back('{func: f, joy_x: x, joy_y: y, z_btn: zb, z_up: zu});
  endtask

  // mostly tick bursts closed by a sample, with loose words mixed in
  task automatic push_random(int n);
    int    left, k;
    func_t f;
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) < 7) begin
        k = $urandom_range(3);
        repeat (k) jog_words_q.push_back(rand_word(FUNC_TICK));
        jog_words_q.push_back(rand_word(FUNC_SAMPLE));
        left -= k + 1;
      end else begin
        case ($urandom_range(7))
          0, 1: f = FUNC_TICK;
          2, 3, 4: f = FUNC_SAMPLE;
          5, 6: f = FUNC_SPEED;
          default: f = FUNC_ORIGIN;
        endcase
        jog_words_q.push_back(rand_word(f));
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (jog_words_q.size() != 0 || exp_motion_q.size() != 0 || in_valid);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(sample_t lo, sample_t hi, period_t p1, period_t p2, period_t p3,
                           period_t p4);
    write_reg(REG_LOW_TH, lo);
    write_reg(REG_HIGH_TH, hi);
    write_reg(REG_PERIOD_1, {2'b00, p1});
    write_reg(REG_PERIOD_2, {2'b00, p2});
    write_reg(REG_PERIOD_3, {2'b00, p3});
    write_reg(REG_PERIOD_4, {2'b00, p4});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    push_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every direction, thresholds hit exactly, speed cycle, origin
    push_word(FUNC_SAMPLE, 10'd550, 10'd550, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd1023, 10'd1023, 1'b1, 1'b1);
    push_word(FUNC_SAMPLE, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd1023, 10'd1023, 1'b1, 1'b1);
    push_word(FUNC_SAMPLE, 10'd500, 10'd600, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd600, 10'd500, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd0, 10'd1023, 1'b1, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd1023, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd550, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd550, 10'd1023, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd1023, 10'd550, 1'b0, 1'b0);
    push_word(FUNC_TICK, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd0, 10'd550, 1'b0, 1'b0);
    repeat (5) push_word(FUNC_SPEED, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_ORIGIN, 10'd1023, 10'd1023, 1'b1, 1'b1);
    push_word(FUNC_SAMPLE, 10'd550, 10'd550, 1'b0, 1'b0);
    wait_drained();

    // writes to unused indexes must be dropped
    write_reg(IDX_SPARE_A, 10'h3FF);
    write_reg(IDX_SPARE_B, 10'h001);
    cfg_valid <= 1'b0;

    // default config, no idling; sender pauses for a full drain mid-way
    push_random(20);
    wait_drained();
    run_phase(20, 0, 0);

    configure(10'd300, 10'd700, 8'd1, 8'd3, 8'd7, 8'd255);
    run_phase(20, 80, 0);

    // crossed thresholds, duplicate periods; long hold-off backs the block up
    configure(10'd700, 10'd300, 8'd4, 8'd4, 8'd20, 8'd2);
    send_idle_pct = 0;
    stall_pct = 80;
    push_random(25);
    hold_request = 60;
    wait_drained();

    // dead zone spans the whole range; period of zero at level four
    configure(10'd0, 10'd1023, 8'd255, 8'd1, 8'd1, 8'd0);
    repeat ((9 - int'(press_cnt)) % 5) push_word(FUNC_SPEED, 10'd0, 10'd0, 1'b0, 1'b0);
    repeat (3) push_word(FUNC_SAMPLE, 10'd0, 10'd1023, 1'b1, 1'b1);
    run_phase(20, 37, 37);

    // long jog from origin so the centimetre values leave zero in both signs,
    // then origin and a resting step that relatches every magnitude
    configure(10'd500, 10'd600, 8'd0, 8'd0, 8'd0, 8'd0);
    send_idle_pct = 0;
    stall_pct = 0;
    push_word(FUNC_ORIGIN, 10'd0, 10'd0, 1'b0, 1'b0);
    repeat (401) push_word(FUNC_SAMPLE, 10'd0, 10'd0, 1'b1, 1'b0);
    push_word(FUNC_ORIGIN, 10'd0, 10'd0, 1'b0, 1'b0);
    push_word(FUNC_SAMPLE, 10'd550, 10'd550, 1'b0, 1'b0);
    wait_drained();

    configure(10'd1023, 10'd0, 8'd1, 8'd2, 8'd3, 8'd4);
    run_phase(15, 37, 37);

    repeat (8) @(posedge clk);
    $display("covered %0d words and %0d results: all directions, crossed/extreme thresholds,",
             n_words, n_results);
    $display("periods 0..255, long jogs with origin resets, stalls and hold-offs; %0d bad",
             n_mismatch);
    if (n_mismatch == 0 && exp_motion_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", exp_motion_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

/* joystick_jog_stepper_controller_unit.f */
src/jjs_pkg.sv
src/jjs_axis.sv
src/joystick_jog_stepper_controller_unit.sv
dv/tb.sv
